// ----- design/assert_macros.svh -----
// assertion macros for the file that checks its own logic
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AST_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define AST_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/utu_pkg.sv -----
// shared types and constants of the utf-8 to utf-16 converter
// no dependencies
package utu_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_UNIT = 2'd0;
	localparam kind_t KIND_PAIR = 2'd1;
	localparam kind_t KIND_ERR  = 2'd2;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	// decoded job passed from front to back; data holds the unit, or the
	// code point minus 0x10000 for a pair
	typedef struct packed {
		kind_t       kind;
		logic [19:0] data;
		logic        last;
	} cmd_t;

endpackage

// ----- design/utu_chan_if.sv -----
// valid/ready channel interfaces for the converter's byte and unit streams
// no dependencies
interface utu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       string_last;

	modport source (output valid, output byte_in, output string_last, input ready);
	modport sink (input valid, input byte_in, input string_last, output ready);
endinterface

interface utu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        error;
	logic        string_end;
	logic        run_last;

	modport source (output valid, output code_unit, output error, output string_end,
		output run_last, input ready);
	modport sink (input valid, input code_unit, input error, input string_end,
		input run_last, output ready);
endinterface

// ----- design/utu_front.sv -----
// front end: accepts bytes, keeps the decoder state, classifies each code point
// depends on utu_pkg and utu_in_if
module utu_front
	import utu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	utu_in_if.sink    in_ch,
	input  logic      queue_full,
	output logic      push,
	output cmd_t      push_cmd
);

	logic [20:0] partial_q;
	logic [1:0]  due_q;
	logic        skip_q;

	logic [20:0] partial_d;
	logic [1:0]  due_d;
	logic        skip_d;
	logic [7:0]  b;
	logic        last;
	logic        accept;
	logic        do_emit;
	logic        do_fail;
	logic        gives;
	logic [20:0] cp;
	logic [20:0] cp_off;
	logic [20:0] shifted;

	assign in_ch.ready = !queue_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign b = in_ch.byte_in;
	assign last = in_ch.string_last;
	assign shifted = {partial_q[14:0], b[5:0]};
	assign cp_off = cp - 21'h010000;

	always_comb begin
		partial_d = partial_q;
		due_d = due_q;
		skip_d = skip_q;
		do_emit = 1'b0;
		do_fail = 1'b0;
		cp = {13'd0, b};
		if (skip_q) begin
			skip_d = !last;
		end else if (due_q == 2'd0) begin
			if (b <= 8'h7F) begin
				do_emit = 1'b1;
			end else if (b <= 8'hBF || b > 8'hF7) begin
				do_fail = 1'b1;
			end else begin
				if (b <= 8'hDF) begin
					partial_d = {16'd0, b[4:0]};
					due_d = 2'd1;
				end else if (b <= 8'hEF) begin
					partial_d = {17'd0, b[3:0]};
					due_d = 2'd2;
				end else begin
					partial_d = {18'd0, b[2:0]};
					due_d = 2'd3;
				end
				do_fail = last;
			end
		end else begin
			cp = shifted;
			if (b < 8'h80 || b > 8'hBF) begin
				do_fail = 1'b1;
			end else begin
				partial_d = shifted;
				due_d = due_q - 2'd1;
				if (due_d == 2'd0) begin
					do_emit = 1'b1;
				end else begin
					do_fail = last;
				end
			end
		end

		push_cmd.kind = KIND_ERR;
		push_cmd.data = '0;
		push_cmd.last = last;
		if (do_emit) begin
			partial_d = '0;
			due_d = 2'd0;
			if ((cp >= 21'h00D800 && cp <= 21'h00DFFF) || cp > 21'h10FFFF) begin
				do_fail = 1'b1;
			end else if (cp <= 21'h00FFFF) begin
				push_cmd.kind = KIND_UNIT;
				push_cmd.data = {4'd0, cp[15:0]};
			end else begin
				push_cmd.kind = KIND_PAIR;
				push_cmd.data = cp_off[19:0];
			end
		end
		if (do_fail) begin
			partial_d = '0;
			due_d = 2'd0;
			skip_d = !last;
			push_cmd.kind = KIND_ERR;
			push_cmd.data = '0;
		end
		gives = do_emit || do_fail;
	end

	assign push = accept && gives;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			due_q <= 2'd0;
			skip_q <= 1'b0;
		end else if (accept) begin
			partial_q <= partial_d;
			due_q <= due_d;
			skip_q <= skip_d;
		end
	end

endmodule

// ----- design/utu_queue.sv -----
// short job queue between front and back ends
// depends on utu_pkg
module utu_queue
	import utu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/utu_back.sv -----
// back end: turns queued jobs into utf-16 units through an output register
// depends on utu_pkg and utu_out_if
module utu_back
	import utu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	utu_out_if.source out_ch
);

	logic        valid_q;
	logic        half_q;
	logic [15:0] unit_q;
	logic        err_q;
	logic        end_q;
	logic        rlast_q;
	logic        load;
	logic        first_half;
	logic [15:0] unit_d;
	logic        err_d;
	logic        end_d;
	logic        rlast_d;

	assign load = !valid_q || out_ch.ready;
	assign first_half = (head.kind == KIND_PAIR) && !half_q;
	assign pop = load && head_valid && !first_half;

	always_comb begin
		unit_d = head.data[15:0];
		err_d = 1'b0;
		end_d = head.last;
		rlast_d = 1'b1;
		case (head.kind)
			KIND_UNIT: begin
				unit_d = head.data[15:0];
			end
			KIND_PAIR: begin
				if (!half_q) begin
					unit_d = {HI_SURR_TAG, head.data[19:10]};
					end_d = 1'b0;
					rlast_d = 1'b0;
				end else begin
					unit_d = {LO_SURR_TAG, head.data[9:0]};
				end
			end
			default: begin
				unit_d = '0;
				err_d = 1'b1;
				end_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				half_q <= first_half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			unit_q <= unit_d;
			err_q <= err_d;
			end_q <= end_d;
			rlast_q <= rlast_d;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.code_unit = unit_q;
	assign out_ch.error = err_q;
	assign out_ch.string_end = end_q;
	assign out_ch.run_last = rlast_q;

endmodule

// ----- design/utf8_to_utf16_strict_converter.sv -----
// channel    dir  payload
// in_ch      in   byte_in[7:0], string_last
// out_ch     out  code_unit[15:0], error, string_end, run_last
//
// one byte accepted per cycle while the job queue has room
// each result is one output unit; a surrogate pair gives two units
// a byte's result is registered first into the queue, then into the output register
// arst_n clears decoder state, queue pointers and output valid at once
// in_ch.ready falls only when the queue is full; out_ch stalls back up through it
module utf8_to_utf16_strict_converter
	import utu_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	utu_in_if.sink    in_ch,
	utu_out_if.source out_ch
);

	`include "assert_macros.svh"

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	utu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	utu_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	utu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

	// error result is always a zero unit closing the string
	`AST_SAME(a_err_form, out_ch.valid && out_ch.error,
		out_ch.code_unit == 16'd0 && out_ch.string_end && out_ch.run_last)
	// only the high surrogate of a pair leaves run_last low
	`AST_SAME(a_high_half, out_ch.valid && !out_ch.run_last,
		out_ch.code_unit[15:10] == HI_SURR_TAG && !out_ch.error && !out_ch.string_end)
	// high surrogate taken means the low one follows straight away
	`AST_NEXT(a_low_follows, out_ch.valid && out_ch.ready && !out_ch.run_last,
		out_ch.valid && out_ch.code_unit[15:10] == LO_SURR_TAG && out_ch.run_last)
	// nothing pushed into a full queue
	`AST_SAME(a_no_overflow, push, !queue_full)

endmodule
